// File: design/ledf_pkg.sv
// Shared types, constants and lookup tables for the LED channel fader.
// No dependencies; used by ledf_front, ledf_back and the top level.
package ledf_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  localparam logic [1:0] OP_SET_CH   = 2'd0;
  localparam logic [1:0] OP_SET_RATE = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;

  localparam logic [7:0] MODE_JUMP = 8'd0;
  localparam logic [7:0] MODE_FADE = 8'd1;

  localparam logic [7:0] STROBE_MAX_RATE = 8'd25;
  localparam logic [5:0] STROBE_SPAN     = 6'd50;

  localparam logic [12:0] PWM_W_CHECK = 13'd4096;

  typedef enum logic [1:0] {
    CMD_SET_CH,
    CMD_SET_RATE,
    CMD_TICK
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [CH_W-1:0]  channel;
    logic [7:0]       level;
    logic [7:0]       mode;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_EMIT
  } back_state_t;

  localparam logic [12:0] CIE_LUT [256] = '{
    13'd0, 13'd1, 13'd3, 13'd13, 13'd14, 13'd15, 13'd16, 13'd17, 13'd18, 13'd19, 13'd20,
    13'd21, 13'd23, 13'd24, 13'd26, 13'd27, 13'd29, 13'd30, 13'd32, 13'd33, 13'd35,
    13'd37, 13'd39, 13'd41, 13'd43, 13'd45, 13'd47, 13'd49, 13'd51, 13'd53, 13'd56,
    13'd58, 13'd61, 13'd63, 13'd66, 13'd68, 13'd71, 13'd74, 13'd77, 13'd80, 13'd83,
    13'd86, 13'd89, 13'd93, 13'd96, 13'd99, 13'd103, 13'd107, 13'd110, 13'd114, 13'd118,
    13'd122, 13'd126, 13'd130, 13'd134, 13'd139, 13'd143, 13'd148, 13'd152, 13'd157,
    13'd162, 13'd166, 13'd171, 13'd176, 13'd182, 13'd187, 13'd192, 13'd198, 13'd203,
    13'd209, 13'd215, 13'd221, 13'd227, 13'd233, 13'd239, 13'd245, 13'd252, 13'd258,
    13'd265, 13'd272, 13'd278, 13'd285, 13'd293, 13'd300, 13'd307, 13'd315, 13'd322,
    13'd330, 13'd338, 13'd346, 13'd354, 13'd362, 13'd370, 13'd379, 13'd387, 13'd396,
    13'd405, 13'd414, 13'd423, 13'd432, 13'd441, 13'd451, 13'd460, 13'd470, 13'd480,
    13'd490, 13'd500, 13'd510, 13'd521, 13'd531, 13'd542, 13'd553, 13'd564, 13'd575,
    13'd587, 13'd598, 13'd610, 13'd621, 13'd633, 13'd645, 13'd657, 13'd670, 13'd682,
    13'd695, 13'd708, 13'd721, 13'd734, 13'd747, 13'd761, 13'd774, 13'd788, 13'd802,
    13'd816, 13'd830, 13'd845, 13'd859, 13'd874, 13'd889, 13'd904, 13'd919, 13'd935,
    13'd950, 13'd966, 13'd982, 13'd998, 13'd1015, 13'd1031, 13'd1048, 13'd1065, 13'd1082,
    13'd1099, 13'd1116, 13'd1134, 13'd1151, 13'd1169, 13'd1187, 13'd1206, 13'd1224,
    13'd1243, 13'd1262, 13'd1281, 13'd1300, 13'd1319, 13'd1339, 13'd1359, 13'd1379,
    13'd1399, 13'd1420, 13'd1440, 13'd1461, 13'd1482, 13'd1503, 13'd1525, 13'd1546,
    13'd1568, 13'd1590, 13'd1612, 13'd1635, 13'd1657, 13'd1680, 13'd1703, 13'd1726,
    13'd1750, 13'd1773, 13'd1797, 13'd1821, 13'd1846, 13'd1870, 13'd1895, 13'd1920,
    13'd1945, 13'd1971, 13'd1996, 13'd2022, 13'd2048, 13'd2074, 13'd2101, 13'd2128,
    13'd2155, 13'd2182, 13'd2209, 13'd2237, 13'd2265, 13'd2293, 13'd2321, 13'd2350,
    13'd2379, 13'd2408, 13'd2437, 13'd2466, 13'd2496, 13'd2526, 13'd2556, 13'd2587,
    13'd2617, 13'd2648, 13'd2680, 13'd2711, 13'd2743, 13'd2775, 13'd2807, 13'd2839,
    13'd2872, 13'd2905, 13'd2938, 13'd2971, 13'd3005, 13'd3039, 13'd3073, 13'd3108,
    13'd3142, 13'd3177, 13'd3212, 13'd3248, 13'd3284, 13'd3320, 13'd3356, 13'd3392,
    13'd3429, 13'd3466, 13'd3503, 13'd3541, 13'd3579, 13'd3617, 13'd3655, 13'd3694,
    13'd3733, 13'd3772, 13'd3812, 13'd3851, 13'd3891, 13'd3932, 13'd3972, 13'd4013,
    13'd4054, PWM_W_CHECK
  };

  // floor(25 / rate) for rates 1..25; one elsewhere
  function automatic logic [5:0] strobe_period(input logic [7:0] rate);
    logic [5:0] p;
    priority if (rate == 8'd1)  p = 6'd25;
    else if (rate == 8'd2)      p = 6'd12;
    else if (rate == 8'd3)      p = 6'd8;
    else if (rate == 8'd4)      p = 6'd6;
    else if (rate == 8'd5)      p = 6'd5;
    else if (rate == 8'd6)      p = 6'd4;
    else if (rate <= 8'd8)      p = 6'd3;
    else if (rate <= 8'd12)     p = 6'd2;
    else                        p = 6'd1;
    return p;
  endfunction

endpackage

// File: design/ledf_front.sv
// Front end: accepts input items, drops those with no effect, and queues
// decoded commands in a two-entry queue. Depends on ledf_pkg.
module ledf_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [1:0]          opcode,
  input  logic [3:0]          channel,
  input  logic [7:0]          level,
  input  logic [7:0]          mode_code,
  output logic                q_valid,
  input  logic                q_ready,
  output ledf_pkg::cmd_t      q_data
);

  ledf_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  ledf_pkg::cmd_t cmd;
  logic           keep;
  logic           do_push;
  logic           do_pop;

  always_comb begin
    cmd.channel = ledf_pkg::CH_W'(channel);
    cmd.level   = level;
    cmd.mode    = mode_code;
    cmd.kind    = ledf_pkg::CMD_TICK;
    keep        = 1'b0;
    unique case (opcode)
      ledf_pkg::OP_SET_CH: begin
        cmd.kind = ledf_pkg::CMD_SET_CH;
        keep     = {1'b0, channel} < 5'(ledf_pkg::NUM_CHANNELS);
      end
      ledf_pkg::OP_SET_RATE: begin
        cmd.kind = ledf_pkg::CMD_SET_RATE;
        keep     = 1'b1;
      end
      ledf_pkg::OP_TICK: begin
        cmd.kind = ledf_pkg::CMD_TICK;
        keep     = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = q[rd_ptr];
  assign do_push = push && !full && keep;
  assign do_pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        q[wr_ptr] <= cmd;
        wr_ptr    <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: design/ledf_back.sv
// Back end: channel state, tick sequencer, strobe logic and the result
// register. Depends on ledf_pkg.
module ledf_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  ledf_pkg::cmd_t      q_data,
  output logic                empty,
  input  logic                pop,
  output logic                has_value,
  output logic [3:0]          out_channel,
  output logic [12:0]         pwm_level,
  output logic                output_enable,
  output logic                last
);

  localparam logic [ledf_pkg::CH_W-1:0] LAST_CH =
    ledf_pkg::CH_W'(ledf_pkg::NUM_CHANNELS - 1);

  logic [7:0] target_level  [ledf_pkg::NUM_CHANNELS];
  logic [7:0] current_level [ledf_pkg::NUM_CHANNELS];
  logic [7:0] channel_mode  [ledf_pkg::NUM_CHANNELS];
  logic [7:0] strobe_rate;
  logic [5:0] strobe_count;
  logic       enable_state;

  ledf_pkg::back_state_t state, state_next;
  logic [ledf_pkg::CH_W-1:0] idx, idx_next;
  logic       changed, changed_next;
  logic       ovalid;

  logic [7:0] cur, tgt, md;
  logic [7:0] mv_level;
  logic       mv_changed;
  logic       slot_free;
  logic       take_cmd;
  logic       do_move;
  logic       do_strobe;
  logic       do_emit;

  logic [5:0] period;
  logic       rate_ok;
  logic [5:0] cnt_a;

  assign cur = current_level[idx];
  assign tgt = target_level[idx];
  assign md  = channel_mode[idx];

  always_comb begin
    mv_level   = cur;
    mv_changed = 1'b0;
    if (md == ledf_pkg::MODE_JUMP) begin
      mv_level   = tgt;
      mv_changed = (cur != tgt);
    end else if (md == ledf_pkg::MODE_FADE) begin
      if (cur > tgt) begin
        mv_level   = cur - 8'd1;
        mv_changed = 1'b1;
      end else if (cur < tgt) begin
        mv_level   = cur + 8'd1;
        mv_changed = 1'b1;
      end
    end
  end

  assign slot_free = !ovalid || pop;
  assign empty     = !ovalid;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    changed_next = changed;
    q_ready      = 1'b0;
    take_cmd     = 1'b0;
    do_move      = 1'b0;
    do_strobe    = 1'b0;
    do_emit      = 1'b0;
    unique case (state)
      ledf_pkg::ST_IDLE: begin
        q_ready  = 1'b1;
        take_cmd = q_valid;
        if (q_valid && q_data.kind == ledf_pkg::CMD_TICK) begin
          state_next   = ledf_pkg::ST_MOVE;
          idx_next     = '0;
          changed_next = 1'b0;
        end
      end
      ledf_pkg::ST_MOVE: begin
        do_move      = 1'b1;
        changed_next = changed | mv_changed;
        if (idx == LAST_CH) begin
          do_strobe  = 1'b1;
          idx_next   = '0;
          state_next = ledf_pkg::ST_EMIT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ledf_pkg::ST_EMIT: begin
        if (slot_free) begin
          do_emit = 1'b1;
          if (!changed || idx == LAST_CH) begin
            state_next = ledf_pkg::ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: state_next = ledf_pkg::ST_IDLE;
    endcase
  end

  assign period  = ledf_pkg::strobe_period(strobe_rate);
  assign rate_ok = (strobe_rate != 8'd0) && (strobe_rate <= ledf_pkg::STROBE_MAX_RATE);
  assign cnt_a   = (strobe_count >= period) ? 6'd0 : strobe_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ledf_pkg::ST_IDLE;
      idx     <= '0;
      changed <= 1'b0;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      changed <= changed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ledf_pkg::NUM_CHANNELS; i++) begin
        target_level[i]  <= 8'd0;
        current_level[i] <= 8'd0;
        channel_mode[i]  <= ledf_pkg::MODE_JUMP;
      end
      strobe_rate  <= 8'd0;
      strobe_count <= 6'd0;
      enable_state <= 1'b1;
    end else begin
      if (take_cmd && q_data.kind == ledf_pkg::CMD_SET_CH) begin
        target_level[q_data.channel] <= q_data.level;
        channel_mode[q_data.channel] <= q_data.mode;
      end
      if (take_cmd && q_data.kind == ledf_pkg::CMD_SET_RATE) begin
        strobe_rate <= q_data.level;
      end
      if (do_move) begin
        current_level[idx] <= mv_level;
      end
      if (do_strobe) begin
        if (rate_ok) begin
          if (strobe_count >= period) begin
            enable_state <= ~enable_state;
          end
          strobe_count <= (cnt_a < ledf_pkg::STROBE_SPAN) ? cnt_a + 6'd1 : 6'd0;
        end else begin
          enable_state <= 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (do_emit) begin
      ovalid <= 1'b1;
    end else if (pop) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_emit) begin
      output_enable <= enable_state;
      if (changed) begin
        has_value   <= 1'b1;
        out_channel <= 4'(idx);
        pwm_level   <= ledf_pkg::CIE_LUT[cur];
        last        <= (idx == LAST_CH);
      end else begin
        has_value   <= 1'b0;
        out_channel <= 4'd0;
        pwm_level   <= 13'd0;
        last        <= 1'b1;
      end
    end
  end

endmodule

// File: design/led_channel_fader_with_strobe.sv
// Top level of the LED channel fader with strobe.
// Depends on ledf_pkg, ledf_front and ledf_back.
//
// Input side is a queue: an item transfers when push is high and full is
// low. Set-channel and set-rate items update state and give no result;
// opcode 3 and out-of-range channels are dropped. A tick walks all
// channels one per cycle to move levels, runs the strobe step with the
// last channel, then emits 16 PWM results, one per cycle while the result
// register is free, or one status result when no channel moved. The back
// end takes no new command until a tick has emitted its results.
// Result side is a queue: the oldest result is on the ports while empty is
// low and transfers when pop is high. A stalled receiver holds the result
// register and halts the back end; the two-entry command queue keeps
// accepting until it fills, then full rises.
// Synchronous reset clears all channel levels, targets and modes (jump),
// the strobe rate and counter, and sets output enable.
module led_channel_fader_with_strobe (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode,
  input  logic [3:0]  channel,
  input  logic [7:0]  level,
  input  logic [7:0]  mode_code,
  output logic        empty,
  input  logic        pop,
  output logic        has_value,
  output logic [3:0]  out_channel,
  output logic [12:0] pwm_level,
  output logic        output_enable,
  output logic        last
);

  logic           q_valid;
  logic           q_ready;
  ledf_pkg::cmd_t q_data;

  ledf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .channel   (channel),
    .level     (level),
    .mode_code (mode_code),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_data    (q_data)
  );

  ledf_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_data        (q_data),
    .empty         (empty),
    .pop           (pop),
    .has_value     (has_value),
    .out_channel   (out_channel),
    .pwm_level     (pwm_level),
    .output_enable (output_enable),
    .last          (last)
  );

endmodule

// File: sim/fader_pwm_checker.sv
// Checker for the LED channel fader: watches both queue ports, predicts
// PWM and status results from accepted commands and compares them.
// Depends on ledf_pkg for opcodes, mode codes and the CIE lookup table.
`timescale 1ns / 1ps

module fader_pwm_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  logic        full,
  input  logic [1:0]  opcode,
  input  logic [3:0]  channel,
  input  logic [7:0]  level,
  input  logic [7:0]  mode_code,
  input  logic        empty,
  input  logic        pop,
  input  logic        has_value,
  input  logic [3:0]  out_channel,
  input  logic [12:0] pwm_level,
  input  logic        output_enable,
  input  logic        last,
  output int          errors,
  output int          waiting
);
  import ledf_pkg::*;

  typedef struct packed {
    logic        has_value;
    logic [3:0]  chan;
    logic [12:0] pwm;
    logic        oe;
    logic        last;
  } pwm_result_t;

  pwm_result_t pending_pwm[$];

  logic [7:0] tgt_lvl [NUM_CHANNELS];
  logic [7:0] cur_lvl [NUM_CHANNELS];
  logic [7:0] ch_mode [NUM_CHANNELS];
  logic [7:0] rate;
  logic [5:0] strobe_cnt;
  logic       oe_state;

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
  endtask

  task automatic apply_command(input logic [1:0] op, input logic [3:0] ch,
                               input logic [7:0] lv, input logic [7:0] md);
    bit          moved;
    int          period;
    pwm_result_t r;
    moved = 1'b0;
    case (op)
      OP_SET_CH: begin
        if (int'(ch) < NUM_CHANNELS) begin
          tgt_lvl[ch] = lv;
          ch_mode[ch] = md;
        end
      end
      OP_SET_RATE: rate = lv;
      OP_TICK: begin
        for (int i = 0; i < NUM_CHANNELS; i++) begin
          if (ch_mode[i] == MODE_JUMP) begin
            if (cur_lvl[i] != tgt_lvl[i]) begin
              cur_lvl[i] = tgt_lvl[i];
              moved = 1'b1;
            end
          end else if (ch_mode[i] == MODE_FADE) begin
            if (cur_lvl[i] > tgt_lvl[i]) begin
              cur_lvl[i] = cur_lvl[i] - 8'd1;
              moved = 1'b1;
            end else if (cur_lvl[i] < tgt_lvl[i]) begin
              cur_lvl[i] = cur_lvl[i] + 8'd1;
              moved = 1'b1;
            end
          end
        end
        // strobe runs after the channels move
        if (rate >= 8'd1 && rate <= STROBE_MAX_RATE) begin
          period = int'(STROBE_MAX_RATE) / int'(rate);
          if (int'(strobe_cnt) >= period) begin
            oe_state = ~oe_state;
            strobe_cnt = '0;
          end
          if (strobe_cnt < STROBE_SPAN) strobe_cnt = strobe_cnt + 6'd1;
          else strobe_cnt = '0;
        end else begin
          oe_state = 1'b1;
        end
        if (!moved) begin
          r = '{has_value: 1'b0, chan: 4'd0, pwm: 13'd0, oe: oe_state, last: 1'b1};
          pending_pwm.push_back(r);
        end else begin
          for (int i = 0; i < NUM_CHANNELS; i++) begin
            r.has_value = 1'b1;
            r.chan      = i[3:0];
            r.pwm       = CIE_LUT[cur_lvl[i]];
            r.oe        = oe_state;
            r.last      = (i == NUM_CHANNELS - 1);
            pending_pwm.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    pwm_result_t want;
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        tgt_lvl[i] = '0;
        cur_lvl[i] = '0;
        ch_mode[i] = MODE_JUMP;
      end
      rate = '0;
      strobe_cnt = '0;
      oe_state = 1'b1;
      pending_pwm.delete();
      errors = 0;
    end else begin
      if (push && !full)
        apply_command(opcode, channel, level, mode_code);
      if (pop && !empty) begin
        if (pending_pwm.size() == 0) begin
          errors++;
          $display({"%0t: unexpected result, expected none, actual has_value=%0d",
                    " ch=%0d pwm=%0d oe=%0d last=%0d"},
                   $time, has_value, out_channel, pwm_level, output_enable, last);
        end else begin
          want = pending_pwm.pop_front();
          if (want.has_value != has_value)
            note_mismatch("has_value", 32'(want.has_value), 32'(has_value));
          if (want.chan != out_channel)
            note_mismatch("out_channel", 32'(want.chan), 32'(out_channel));
          if (want.pwm != pwm_level)
            note_mismatch("pwm_level", 32'(want.pwm), 32'(pwm_level));
          if (want.oe != output_enable)
            note_mismatch("output_enable", 32'(want.oe), 32'(output_enable));
          if (want.last != last)
            note_mismatch("last", 32'(want.last), 32'(last));
        end
      end
    end
    waiting <= pending_pwm.size();
  end

endmodule

// File: sim/testbench.sv
// Top of the LED channel fader test: clock, reset, command stimulus with
// bursts and gaps, a stalling receiver, watchdog and verdict.
// Depends on ledf_pkg, led_channel_fader_with_strobe and fader_pwm_checker.
`timescale 1ns / 1ps

module testbench;
  import ledf_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int RANDOM_ITEMS = 272;
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef enum {POP_ALWAYS, POP_COIN, POP_SPARSE, POP_SQUARE} pop_style_t;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [1:0]  opcode;
  logic [3:0]  channel;
  logic [7:0]  level;
  logic [7:0]  mode_code;
  logic        empty;
  logic        pop;
  logic        has_value;
  logic [3:0]  out_channel;
  logic [12:0] pwm_level;
  logic        output_enable;
  logic        last;

  int fails;
  int waiting;
  int burst_left;
  int quiet_cycles;
  bit hold_request;
  bit hold_served;

  led_channel_fader_with_strobe u_top (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .channel(channel), .level(level), .mode_code(mode_code), .empty(empty),
    .pop(pop), .has_value(has_value), .out_channel(out_channel),
    .pwm_level(pwm_level), .output_enable(output_enable), .last(last)
  );

  fader_pwm_checker u_check (
    .clk(clk), .rst(rst), .push(push), .full(full), .opcode(opcode),
    .channel(channel), .level(level), .mode_code(mode_code), .empty(empty),
    .pop(pop), .has_value(has_value), .out_channel(out_channel),
    .pwm_level(pwm_level), .output_enable(output_enable), .last(last),
    .errors(fails), .waiting(waiting)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one command transfer, then the gap that ends a burst
  task automatic issue(input logic [1:0] op, input logic [3:0] ch,
                       input logic [7:0] lv, input logic [7:0] md);
    int gap;
    push <= 1'b1;
    opcode <= op;
    channel <= ch;
    level <= lv;
    mode_code <= md;
    @(posedge clk);
    while (full) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      case ($urandom_range(7, 0))
        0, 1:    gap = 0;
        7:       gap = $urandom_range(40, 10);
        default: gap = $urandom_range(5, 1);
      endcase
      repeat (gap) begin
        push <= 1'b0;
        opcode <= 2'($urandom);
        channel <= 4'($urandom);
        level <= 8'($urandom);
        mode_code <= 8'($urandom);
        @(posedge clk);
      end
      burst_left = $urandom_range(15, 0);
    end
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  initial begin : receiver
    int         seg;
    int         k;
    pop_style_t style;
    pop = 1'b0;
    hold_served = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        seg = $urandom_range(200, 20);
        style = pop_style_t'($urandom_range(3, 0));
        for (k = 0; k < seg && !(hold_request && !hold_served); k++) begin
          case (style)
            POP_ALWAYS: pop <= 1'b1;
            POP_COIN:   pop <= 1'($urandom_range(1, 0));
            POP_SPARSE: pop <= ($urandom_range(7, 0) == 0);
            default:    pop <= ((k / 6) % 2 == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    int         n;
    int         sel;
    logic [1:0] op;
    logic [3:0] ch;
    logic [7:0] lv;
    logic [7:0] md;
    rst = 1'b1;
    push = 1'b0;
    opcode = OP_SET_CH;
    channel = '0;
    level = '0;
    mode_code = '0;
    hold_request = 1'b0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: status tick, jump/fade/hold modes, strobe rate extremes
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_SET_CH, 4'd0, 8'hFF, MODE_JUMP);
    issue(OP_SET_CH, 4'd15, 8'd1, MODE_FADE);
    issue(OP_SET_CH, 4'd1, 8'd128, 8'd2);
    issue(OP_SET_CH, 4'd2, 8'd200, 8'hFF);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_TICK, 4'd15, 8'hFF, 8'hFF);
    issue(OP_SET_CH, 4'd15, 8'd0, MODE_FADE);
    issue(OP_SET_RATE, 4'd0, STROBE_MAX_RATE, 8'd0);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_SET_RATE, 4'd0, 8'd1, 8'd0);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_SET_RATE, 4'd0, 8'd26, 8'd0);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_SET_RATE, 4'd0, 8'hFF, 8'd0);
    issue(OP_SET_CH, 4'd0, 8'd0, MODE_FADE);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);
    issue(OP_NONE, 4'd15, 8'hFF, 8'hFF);
    issue(OP_SET_RATE, 4'd0, 8'd0, 8'd0);
    issue(OP_SET_CH, 4'd0, 8'd0, MODE_JUMP);
    issue(OP_SET_CH, 4'd7, 8'd255, MODE_FADE);
    issue(OP_TICK, 4'd0, 8'd0, 8'd0);

    // receiver holds off while commands keep coming, so full must rise
    hold_request <= 1'b1;
    burst_left = 30;
    for (n = 0; n < 24; n++) begin
      ch = 4'($urandom);
      lv = 8'($urandom);
      if (n % 3 == 2) issue(OP_SET_CH, ch, lv, MODE_JUMP);
      else issue(OP_TICK, ch, lv, 8'd0);
    end
    wait_drained();

    n = 0;
    while (n < RANDOM_ITEMS) begin
      sel = $urandom_range(99, 0);
      ch = 4'($urandom);
      lv = 8'($urandom);
      md = 8'($urandom);
      if (sel < 3) begin
        op = OP_NONE;
      end else if (sel < 48) begin
        op = OP_TICK;
      end else if (sel < 60) begin
        op = OP_SET_RATE;
        if ($urandom_range(9, 0) < 7) lv = 8'($urandom_range(25, 1));
      end else begin
        op = OP_SET_CH;
        sel = $urandom_range(9, 0);
        if (sel < 4) md = MODE_JUMP;
        else if (sel < 8) md = MODE_FADE;
        if ($urandom_range(7, 0) == 0) lv = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      end
      issue(op, ch, lv, md);
      if (op != OP_NONE) begin
        n++;
        if (n == RANDOM_ITEMS / 2) wait_drained();
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (waiting != 0)
      $display("%0t: %0d expected results never arrived", $time, waiting);
    if (fails == 0 && waiting == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
